/* rtl/dihc_pkg.sv */
// Shared types, type codes and dependency functions for the dual-issue hazard control block.
package dihc_pkg;

  // Instruction type codes. Codes above T_SPECIAL behave as ALU work with no registers.
  localparam logic [3:0] T_NOP     = 4'd0;
  localparam logic [3:0] T_RTYPE   = 4'd1;
  localparam logic [3:0] T_ITYPE   = 4'd2;
  localparam logic [3:0] T_LOAD    = 4'd3;
  localparam logic [3:0] T_STORE   = 4'd4;
  localparam logic [3:0] T_BRANCH  = 4'd5;
  localparam logic [3:0] T_JUMP    = 4'd6;
  localparam logic [3:0] T_JREG    = 4'd7;
  localparam logic [3:0] T_SPECIAL = 4'd8;

  // One instruction as it travels down a lane.
  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  src_a;
    logic [7:0]  src_b;
    logic [7:0]  dest;
    logic [31:0] pc;
  } insn_t;

  localparam insn_t NOP_INSN = '{kind: T_NOP, src_a: 8'd0, src_b: 8'd0, dest: 8'd0, pc: 32'd0};

  // One result item.
  typedef struct packed {
    logic [1:0] consumed;
    logic       finished;
    insn_t      alu;
    insn_t      ls;
  } result_t;

  // Loads and stores go to the load/store lane.
  function automatic logic is_mem(insn_t p);
    return (p.kind == T_LOAD) || (p.kind == T_STORE);
  endfunction

  // Branch, jump and jump register redirect fetch.
  function automatic logic is_ctrl(insn_t p);
    return (p.kind == T_BRANCH) || (p.kind == T_JUMP) || (p.kind == T_JREG);
  endfunction

  function automatic logic writes_reg(insn_t p);
    return (p.kind == T_LOAD) || (p.kind == T_RTYPE) || (p.kind == T_ITYPE);
  endfunction

  // True when instruction q reads register r.
  function automatic logic reads_reg(insn_t q, logic [7:0] r);
    logic hit;
    hit = 1'b0;
    case (q.kind) inside
      T_STORE, T_RTYPE, T_BRANCH: hit = (q.src_a == r) || (q.src_b == r);
      T_JREG, T_ITYPE, T_LOAD:    hit = (q.src_a == r);
      default:                    hit = 1'b0;
    endcase
    return hit;
  endfunction

  // True when q needs the result that p writes.
  function automatic logic depends(insn_t p, insn_t q);
    return writes_reg(p) && reads_reg(q, p.dest);
  endfunction

endpackage

/* rtl/dihc_issue.sv */
// Issue slotting: places the two oldest pending instructions into the fetch slots.
module dihc_issue (
  input  logic           first_valid_i,
  input  logic           second_valid_i,
  input  dihc_pkg::insn_t first_i,
  input  dihc_pkg::insn_t second_i,
  output dihc_pkg::insn_t alu_slot_o,
  output dihc_pkg::insn_t ls_slot_o,
  output logic [1:0]     consumed_o
);
  import dihc_pkg::*;

  insn_t first;
  insn_t second;
  logic  pair;

  // A missing second instruction counts as a nop; a missing first ends the trace.
  assign first  = first_valid_i ? first_i : NOP_INSN;
  assign second = (first_valid_i && second_valid_i) ? second_i : NOP_INSN;

  // Pair two instructions only when they suit different lanes and are independent.
  always_comb begin
    alu_slot_o = NOP_INSN;
    ls_slot_o  = NOP_INSN;
    pair       = 1'b0;
    if (first_valid_i) begin
      if (is_mem(first)) begin
        ls_slot_o = first;
        if (!depends(first, second) && !is_mem(second)) begin
          alu_slot_o = second;
          pair       = 1'b1;
        end
      end else if (is_ctrl(first)) begin
        alu_slot_o = first;
      end else begin
        alu_slot_o = first;
        if (!depends(first, second) && is_mem(second)) begin
          ls_slot_o = second;
          pair      = 1'b1;
        end
      end
    end
  end

  // Count only instructions that were really present.
  always_comb begin
    consumed_o = 2'd0;
    if (first_valid_i) begin
      consumed_o = (pair && second_valid_i) ? 2'd2 : 2'd1;
    end
  end

endmodule

/* rtl/dual_issue_pipeline_hazard_control.sv */
// Top level: two-lane in-order pipeline state, hazard detection and the result buffer.
// The result of an item is registered in the output buffer when the item is accepted.
// Throughput: one item per cycle while in_stall_o is low; the pipeline state advances once per accepted item.
// A two-entry output buffer keeps items flowing while one result waits to be taken.
// Reset clears all stages and fetch slots to nops, reloads the drain counter
// with DRAIN_CYCLES and leaves the block not halted with an empty output buffer.
module dual_issue_pipeline_hazard_control #(
  parameter int DRAIN_CYCLES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        first_valid_i,
  input  logic [3:0]  first_type_i,
  input  logic [7:0]  first_src_a_i,
  input  logic [7:0]  first_src_b_i,
  input  logic [7:0]  first_dest_i,
  input  logic [31:0] first_pc_i,
  input  logic        second_valid_i,
  input  logic [3:0]  second_type_i,
  input  logic [7:0]  second_src_a_i,
  input  logic [7:0]  second_src_b_i,
  input  logic [7:0]  second_dest_i,
  input  logic [31:0] second_pc_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  consumed_o,
  output logic        finished_o,
  output logic [3:0]  alu_type_o,
  output logic [7:0]  alu_src_a_o,
  output logic [7:0]  alu_src_b_o,
  output logic [7:0]  alu_dest_o,
  output logic [31:0] alu_pc_o,
  output logic [3:0]  ls_type_o,
  output logic [7:0]  ls_src_a_o,
  output logic [7:0]  ls_src_b_o,
  output logic [7:0]  ls_dest_o,
  output logic [31:0] ls_pc_o
);
  import dihc_pkg::*;

  localparam int DW = $clog2(DRAIN_CYCLES + 1);
  // IF/ID, ID/EX and EX/MEM are stored; MEM/WB lives in the result register.
  localparam int NSTG = 3;

  insn_t   fetch_q [2];
  insn_t   alu_st_q [NSTG];
  insn_t   ls_st_q [NSTG];
  logic [DW-1:0] drain_q;
  logic    halted_q;

  result_t main_q, skid_q, res;
  logic    main_v_q, skid_v_q;

  insn_t   first, second, alu_slot, ls_slot;
  logic [1:0] consumed;
  logic    in_acc, out_acc, halt_now, stall, control, advance_fetch;

  assign in_acc  = in_valid_i && !skid_v_q;
  assign out_acc = main_v_q && !out_stall_i;
  assign in_stall_o = skid_v_q;

  assign first  = '{kind: first_type_i, src_a: first_src_a_i, src_b: first_src_b_i,
                    dest: first_dest_i, pc: first_pc_i};
  assign second = '{kind: second_type_i, src_a: second_src_a_i, src_b: second_src_b_i,
                    dest: second_dest_i, pc: second_pc_i};

  dihc_issue u_issue (
    .first_valid_i  (first_valid_i),
    .second_valid_i (second_valid_i),
    .first_i        (first),
    .second_i       (second),
    .alu_slot_o     (alu_slot),
    .ls_slot_o      (ls_slot),
    .consumed_o     (consumed)
  );

  // Halt once the trace has ended and draining is complete.
  assign halt_now = halted_q || (!first_valid_i && (drain_q == '0));

  // Load-use hazard against either instruction in decode, and the control bubble behind a branch or jump.
  assign stall = (ls_st_q[1].kind == T_LOAD) &&
                 (reads_reg(alu_st_q[0], ls_st_q[1].dest) ||
                  reads_reg(ls_st_q[0], ls_st_q[1].dest));
  assign control = is_ctrl(alu_st_q[0]);
  assign advance_fetch = !stall && !control;

  // Result of this item: the instructions moving into writeback.
  always_comb begin
    res.consumed = 2'd0;
    res.finished = 1'b0;
    res.alu      = alu_st_q[2];
    res.ls       = ls_st_q[2];
    if (halt_now) begin
      res.finished = 1'b1;
      res.alu      = NOP_INSN;
      res.ls       = NOP_INSN;
    end else if (advance_fetch) begin
      res.consumed = consumed;
    end
  end

  // Pipeline state advances once per accepted item until the block halts; fetch state only with no stall or bubble.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        fetch_q[i] <= NOP_INSN;
      end
      for (int i = 0; i < NSTG; i++) begin
        alu_st_q[i] <= NOP_INSN;
        ls_st_q[i]  <= NOP_INSN;
      end
      drain_q  <= DRAIN_CYCLES[DW-1:0];
      halted_q <= 1'b0;
    end else if (in_acc) begin
      if (halt_now) begin
        halted_q <= 1'b1;
      end else begin
        alu_st_q[2] <= alu_st_q[1];
        ls_st_q[2]  <= ls_st_q[1];
        if (stall) begin
          alu_st_q[1] <= NOP_INSN;
          ls_st_q[1]  <= NOP_INSN;
        end else begin
          alu_st_q[1] <= alu_st_q[0];
          ls_st_q[1]  <= ls_st_q[0];
          if (control) begin
            alu_st_q[0] <= NOP_INSN;
            ls_st_q[0]  <= NOP_INSN;
          end else begin
            alu_st_q[0] <= fetch_q[0];
            ls_st_q[0]  <= fetch_q[1];
          end
        end
        if (advance_fetch) begin
          fetch_q[0] <= alu_slot;
          fetch_q[1] <= ls_slot;
          if (!first_valid_i && (drain_q != '0)) begin
            drain_q <= drain_q - DW'(1);
          end
        end
      end
    end
  end

  // Two-entry output buffer: main register plus a skid entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (skid_v_q) begin
        if (out_acc) begin
          main_v_q <= 1'b1;
          skid_v_q <= 1'b0;
        end
      end else if (in_acc) begin
        main_v_q <= 1'b1;
        if (main_v_q && !out_acc) begin
          skid_v_q <= 1'b1;
        end
      end else if (out_acc) begin
        main_v_q <= 1'b0;
      end
    end
  end

  // Payload side of the output buffer.
  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_acc) begin
        main_q <= skid_q;
      end
    end else if (in_acc) begin
      if (!main_v_q || out_acc) begin
        main_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o = main_v_q;
  assign consumed_o  = main_q.consumed;
  assign finished_o  = main_q.finished;
  assign alu_type_o  = main_q.alu.kind;
  assign alu_src_a_o = main_q.alu.src_a;
  assign alu_src_b_o = main_q.alu.src_b;
  assign alu_dest_o  = main_q.alu.dest;
  assign alu_pc_o    = main_q.alu.pc;
  assign ls_type_o   = main_q.ls.kind;
  assign ls_src_a_o  = main_q.ls.src_a;
  assign ls_src_b_o  = main_q.ls.src_b;
  assign ls_dest_o   = main_q.ls.dest;
  assign ls_pc_o     = main_q.ls.pc;

endmodule

/* verif/tb_dual_issue_pipeline_hazard_control.sv */
// Self-checking testbench for the dual-issue hazard control block with a built-in lane predictor.
`timescale 1ns / 100ps

module tb_dual_issue_pipeline_hazard_control;
  import dihc_pkg::*;

  localparam int DRAIN     = 4;
  localparam int RAND_PAIRS = 800;
  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;

  // One input item: the two oldest pending instructions.
  typedef struct packed {
    logic  fv;
    insn_t first;
    logic  sv;
    insn_t second;
  } pair_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        first_valid_i = 1'b0;
  logic [3:0]  first_type_i = 4'd0;
  logic [7:0]  first_src_a_i = 8'd0;
  logic [7:0]  first_src_b_i = 8'd0;
  logic [7:0]  first_dest_i = 8'd0;
  logic [31:0] first_pc_i = 32'd0;
  logic        second_valid_i = 1'b0;
  logic [3:0]  second_type_i = 4'd0;
  logic [7:0]  second_src_a_i = 8'd0;
  logic [7:0]  second_src_b_i = 8'd0;
  logic [7:0]  second_dest_i = 8'd0;
  logic [31:0] second_pc_i = 32'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  consumed_o;
  logic        finished_o;
  logic [3:0]  alu_type_o;
  logic [7:0]  alu_src_a_o;
  logic [7:0]  alu_src_b_o;
  logic [7:0]  alu_dest_o;
  logic [31:0] alu_pc_o;
  logic [3:0]  ls_type_o;
  logic [7:0]  ls_src_a_o;
  logic [7:0]  ls_src_b_o;
  logic [7:0]  ls_dest_o;
  logic [31:0] ls_pc_o;

  dual_issue_pipeline_hazard_control #(
    .DRAIN_CYCLES(DRAIN)
  ) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .first_valid_i(first_valid_i), .first_type_i(first_type_i),
    .first_src_a_i(first_src_a_i), .first_src_b_i(first_src_b_i),
    .first_dest_i(first_dest_i), .first_pc_i(first_pc_i),
    .second_valid_i(second_valid_i), .second_type_i(second_type_i),
    .second_src_a_i(second_src_a_i), .second_src_b_i(second_src_b_i),
    .second_dest_i(second_dest_i), .second_pc_i(second_pc_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .consumed_o(consumed_o), .finished_o(finished_o),
    .alu_type_o(alu_type_o), .alu_src_a_o(alu_src_a_o), .alu_src_b_o(alu_src_b_o),
    .alu_dest_o(alu_dest_o), .alu_pc_o(alu_pc_o),
    .ls_type_o(ls_type_o), .ls_src_a_o(ls_src_a_o), .ls_src_b_o(ls_src_b_o),
    .ls_dest_o(ls_dest_o), .ls_pc_o(ls_pc_o)
  );

  // Stimulus, expected retirements and run bookkeeping.
  pair_t   pending[$];
  result_t retire_q[$];
  int      total_items = 0;
  int      items_taken = 0;
  int      results_seen = 0;
  int      mismatches = 0;
  int      tx_gap = 0;
  int      rx_gap = 0;
  int      hold_left = 0;
  logic    hold_done = 1'b0;
  int      quiet_cycles = 0;
  logic    idle_ok;

  // Predictor state: fetch slots (0 = ALU, 1 = load/store) and the two lanes.
  insn_t      fetch_q[2];
  insn_t      alu_pipe[4];
  insn_t      ls_pipe[4];
  logic [2:0] drain_cnt;
  logic       halted_m;
  int         dual_issues = 0;
  int         load_stalls = 0;
  int         branch_bubbles = 0;

  // Idling is off during the last stretch and during every third block of items.
  assign idle_ok = (items_taken < total_items - 120) && ((items_taken / 128) % 3 != 2);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic mem_lane(insn_t p);
    return (p.kind == T_LOAD) || (p.kind == T_STORE);
  endfunction

  function automatic logic redirects(insn_t p);
    return (p.kind == T_BRANCH) || (p.kind == T_JUMP) || (p.kind == T_JREG);
  endfunction

  function automatic logic writes_dest(insn_t p);
    return (p.kind == T_RTYPE) || (p.kind == T_ITYPE) || (p.kind == T_LOAD);
  endfunction

  // Which source fields an instruction really reads depends on its type.
  function automatic logic uses_reg(insn_t q, logic [7:0] r);
    logic hit;
    hit = 1'b0;
    case (q.kind)
      T_RTYPE, T_STORE, T_BRANCH: hit = (q.src_a == r) || (q.src_b == r);
      T_ITYPE, T_LOAD, T_JREG:    hit = (q.src_a == r);
      default:                    hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic feeds(insn_t p, insn_t q);
    return writes_dest(p) && uses_reg(q, p.dest);
  endfunction

  // Advance the modeled pipeline by one accepted item and return what leaves writeback.
  function automatic result_t advance_pipeline(pair_t x);
    result_t    r;
    insn_t      a;
    insn_t      b;
    logic       hold_fetch;
    logic       bubble;
    logic       paired;
    logic [7:0] ld_reg;
    r = '0;
    a = NOP_INSN;
    b = NOP_INSN;
    paired = 1'b0;
    if (!halted_m && !x.fv && drain_cnt == 3'd0) halted_m = 1'b1;
    if (halted_m) begin
      r.finished = 1'b1;
      return r;
    end
    if (x.fv) begin
      a = x.first;
      if (x.sv) b = x.second;
    end
    // Load-use hazard against either decode slot, and a control bubble behind a branch or jump.
    ld_reg = ls_pipe[1].dest;
    hold_fetch = (ls_pipe[1].kind == T_LOAD) &&
                 (uses_reg(alu_pipe[0], ld_reg) || uses_reg(ls_pipe[0], ld_reg));
    bubble = redirects(alu_pipe[0]);
    alu_pipe[3] = alu_pipe[2];
    alu_pipe[2] = alu_pipe[1];
    ls_pipe[3] = ls_pipe[2];
    ls_pipe[2] = ls_pipe[1];
    if (hold_fetch) begin
      alu_pipe[1] = NOP_INSN;
      ls_pipe[1] = NOP_INSN;
      load_stalls++;
    end else begin
      alu_pipe[1] = alu_pipe[0];
      ls_pipe[1] = ls_pipe[0];
      if (bubble) begin
        alu_pipe[0] = NOP_INSN;
        ls_pipe[0] = NOP_INSN;
        branch_bubbles++;
      end else begin
        alu_pipe[0] = fetch_q[0];
        ls_pipe[0] = fetch_q[1];
      end
    end
    // Fill the fetch slots, pairing when lanes differ and there is no dependency.
    if (!hold_fetch && !bubble) begin
      if (!x.fv) begin
        if (drain_cnt > 3'd0) drain_cnt = drain_cnt - 3'd1;
        fetch_q[0] = NOP_INSN;
        fetch_q[1] = NOP_INSN;
      end else begin
        if (mem_lane(a)) begin
          fetch_q[1] = a;
          paired = !feeds(a, b) && !mem_lane(b);
          fetch_q[0] = paired ? b : NOP_INSN;
        end else if (redirects(a)) begin
          fetch_q[0] = a;
          fetch_q[1] = NOP_INSN;
        end else begin
          fetch_q[0] = a;
          paired = !feeds(a, b) && mem_lane(b);
          fetch_q[1] = paired ? b : NOP_INSN;
        end
        r.consumed = (paired && x.sv) ? 2'd2 : 2'd1;
        if (r.consumed == 2'd2) dual_issues++;
      end
    end
    r.alu = alu_pipe[3];
    r.ls = ls_pipe[3];
    return r;
  endfunction

  function automatic insn_t make_insn(logic [3:0] k, logic [7:0] a, logic [7:0] b,
                                      logic [7:0] d, logic [31:0] pc);
    insn_t i;
    i.kind = k;
    i.src_a = a;
    i.src_b = b;
    i.dest = d;
    i.pc = pc;
    return i;
  endfunction

  function automatic void add_pair(logic fv, insn_t f, logic sv, insn_t s);
    pair_t p;
    p.fv = fv;
    p.first = f;
    p.sv = sv;
    p.second = s;
    pending.push_back(p);
  endfunction

  // Mostly a small register pool so that dependencies and load-use hazards are common.
  function automatic logic [7:0] random_reg();
    return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 7));
  endfunction

  function automatic insn_t random_insn();
    int         roll;
    logic [3:0] k;
    roll = $urandom_range(0, 99);
    if (roll < 25)      k = T_RTYPE;
    else if (roll < 40) k = T_ITYPE;
    else if (roll < 58) k = T_LOAD;
    else if (roll < 72) k = T_STORE;
    else if (roll < 80) k = T_BRANCH;
    else if (roll < 85) k = T_JUMP;
    else if (roll < 89) k = T_JREG;
    else if (roll < 92) k = T_NOP;
    else if (roll < 95) k = T_SPECIAL;
    else                k = 4'($urandom_range(9, 15));
    return make_insn(k, random_reg(), random_reg(), random_reg(), $urandom());
  endfunction

  // Compare one field of a retirement against its prediction.
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result %0d %s mismatch: expected 0x%0h, got 0x%0h",
                 $time, results_seen, name, want, got);
    end
  endtask

  // Driver: offers queued items and predicts each one as it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin : drive_items
    pair_t   nx;
    pair_t   cur;
    result_t want;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_gap <= 0;
      fetch_q[0] = NOP_INSN;
      fetch_q[1] = NOP_INSN;
      for (int s = 0; s < 4; s++) begin
        alu_pipe[s] = NOP_INSN;
        ls_pipe[s] = NOP_INSN;
      end
      drain_cnt = 3'(DRAIN);
      halted_m = 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        cur.fv = first_valid_i;
        cur.first = make_insn(first_type_i, first_src_a_i, first_src_b_i,
                              first_dest_i, first_pc_i);
        cur.sv = second_valid_i;
        cur.second = make_insn(second_type_i, second_src_a_i, second_src_b_i,
                               second_dest_i, second_pc_i);
        want = advance_pipeline(cur);
        retire_q.push_back(want);
        items_taken <= items_taken + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid_i <= 1'b0;
        end else if (idle_ok && hold_left == 0 && $urandom_range(0, 9) == 0) begin
          tx_gap <= $urandom_range(0, 16);
          in_valid_i <= 1'b0;
        end else if (pending.size() > 0) begin
          nx = pending.pop_front();
          first_valid_i <= nx.fv;
          first_type_i <= nx.first.kind;
          first_src_a_i <= nx.first.src_a;
          first_src_b_i <= nx.first.src_b;
          first_dest_i <= nx.first.dest;
          first_pc_i <= nx.first.pc;
          second_valid_i <= nx.sv;
          second_type_i <= nx.second.kind;
          second_src_a_i <= nx.second.src_a;
          second_src_b_i <= nx.second.src_b;
          second_dest_i <= nx.second.dest;
          second_pc_i <= nx.second.pc;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off partway through, so the block backs up into its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && items_taken >= 300) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver stall: random bursts, or the long hold-off above.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_gap <= 0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_stall_i <= 1'b1;
    end else if (idle_ok && $urandom_range(0, 9) == 0) begin
      rx_gap <= $urandom_range(0, 16);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: every retirement is checked against the oldest prediction.
  always @(posedge clk_i) begin : watch_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (retire_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result %0d arrived with no prediction waiting", $time, results_seen);
      end else begin
        want = retire_q.pop_front();
        check_field("consumed", 32'(want.consumed), 32'(consumed_o));
        check_field("finished", 32'(want.finished), 32'(finished_o));
        check_field("alu_type", 32'(want.alu.kind), 32'(alu_type_o));
        check_field("alu_src_a", 32'(want.alu.src_a), 32'(alu_src_a_o));
        check_field("alu_src_b", 32'(want.alu.src_b), 32'(alu_src_b_o));
        check_field("alu_dest", 32'(want.alu.dest), 32'(alu_dest_o));
        check_field("alu_pc", want.alu.pc, alu_pc_o);
        check_field("ls_type", 32'(want.ls.kind), 32'(ls_type_o));
        check_field("ls_src_a", 32'(want.ls.src_a), 32'(ls_src_a_o));
        check_field("ls_src_b", 32'(want.ls.src_b), 32'(ls_src_b_o));
        check_field("ls_dest", 32'(want.ls.dest), 32'(ls_dest_o));
        check_field("ls_pc", want.ls.pc, ls_pc_o);
      end
      results_seen <= results_seen + 1;
    end
  end

  // Watchdog: too long with no handshake on either side ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("** dual_issue_pipeline_hazard_control: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int    ends_left;
    pair_t p;
    // Directed: extremes, every type, pairing rules and the hazard cases.
    add_pair(1'b1, NOP_INSN, 1'b1, NOP_INSN);
    add_pair(1'b1, make_insn(T_RTYPE, 8'd2, 8'd3, 8'd1, 32'h100),
             1'b1, make_insn(T_STORE, 8'd4, 8'd1, 8'd0, 32'h104));
    add_pair(1'b1, make_insn(T_RTYPE, 8'd5, 8'd6, 8'd7, 32'h108),
             1'b1, make_insn(T_LOAD, 8'd8, 8'd0, 8'd9, 32'h10c));
    add_pair(1'b1, make_insn(T_LOAD, 8'd1, 8'd0, 8'd6, 32'h110),
             1'b1, make_insn(T_RTYPE, 8'd6, 8'd2, 8'd3, 32'h114));
    // This reader of the load above should cause a load-use stall.
    add_pair(1'b1, make_insn(T_ITYPE, 8'd6, 8'd0, 8'd10, 32'h118), 1'b1, NOP_INSN);
    add_pair(1'b1, make_insn(T_STORE, 8'd10, 8'd11, 8'd0, 32'h11c),
             1'b1, make_insn(T_ITYPE, 8'd12, 8'd0, 8'd13, 32'h120));
    add_pair(1'b1, make_insn(T_LOAD, 8'd1, 8'd0, 8'd2, 32'h124),
             1'b1, make_insn(T_LOAD, 8'd3, 8'd0, 8'd4, 32'h128));
    // A memory op paired with a missing second instruction still counts once.
    add_pair(1'b1, make_insn(T_STORE, 8'd2, 8'd5, 8'd0, 32'h12c),
             1'b0, make_insn(T_RTYPE, 8'd9, 8'd9, 8'd9, 32'hdead));
    add_pair(1'b1, make_insn(T_BRANCH, 8'd2, 8'd3, 8'd0, 32'h130),
             1'b1, make_insn(T_RTYPE, 8'd1, 8'd1, 8'd1, 32'h134));
    add_pair(1'b1, make_insn(T_JUMP, 8'd0, 8'd0, 8'd0, 32'h138),
             1'b1, make_insn(T_STORE, 8'd1, 8'd2, 8'd0, 32'h13c));
    add_pair(1'b1, make_insn(T_JREG, 8'd7, 8'd0, 8'd0, 32'h140),
             1'b1, make_insn(T_LOAD, 8'd7, 8'd0, 8'd7, 32'h144));
    add_pair(1'b1, make_insn(T_SPECIAL, 8'd1, 8'd2, 8'd3, 32'h148),
             1'b1, make_insn(T_STORE, 8'd3, 8'd3, 8'd0, 32'h14c));
    add_pair(1'b1, make_insn(4'hf, 8'hff, 8'hff, 8'hff, 32'hffff_ffff),
             1'b1, make_insn(4'hf, 8'hff, 8'hff, 8'hff, 32'hffff_ffff));
    add_pair(1'b1, make_insn(T_RTYPE, 8'hff, 8'hff, 8'hff, 32'hffff_fff0),
             1'b1, make_insn(T_STORE, 8'hff, 8'hff, 8'hff, 32'hffff_fff4));
    add_pair(1'b1, make_insn(T_ITYPE, 8'd1, 8'd0, 8'd2, 32'h150),
             1'b1, make_insn(4'd9, 8'd2, 8'd2, 8'd2, 32'h154));
    // Trace runs dry for one item, then resumes.
    add_pair(1'b0, make_insn(4'hf, 8'hff, 8'hff, 8'hff, 32'hffff_ffff),
             1'b1, make_insn(4'hf, 8'hff, 8'hff, 8'hff, 32'hffff_ffff));
    add_pair(1'b1, make_insn(T_LOAD, 8'd0, 8'd0, 8'd0, 32'h0),
             1'b1, make_insn(T_RTYPE, 8'd0, 8'd0, 8'd0, 32'h4));
    add_pair(1'b1, make_insn(T_RTYPE, 8'd0, 8'd1, 8'd2, 32'h8), 1'b1, NOP_INSN);
    add_pair(1'b1, make_insn(T_BRANCH, 8'd2, 8'd0, 8'd0, 32'hc), 1'b0, NOP_INSN);
    add_pair(1'b1, NOP_INSN, 1'b1, make_insn(T_STORE, 8'd4, 8'd5, 8'd0, 32'h10));

    // Random traces; at most two early trace ends so draining never completes early.
    ends_left = 2;
    for (int n = 0; n < RAND_PAIRS; n++) begin
      p.fv = 1'b1;
      if (ends_left > 0 && $urandom_range(0, 149) == 0) begin
        p.fv = 1'b0;
        ends_left--;
      end
      p.first = random_insn();
      p.sv = ($urandom_range(0, 9) != 0);
      p.second = random_insn();
      pending.push_back(p);
    end

    // End of trace: drain to completion, then check that the halted block ignores input.
    for (int n = 0; n < 16; n++) begin
      p.fv = (n >= 10);
      p.first = random_insn();
      p.sv = 1'($urandom_range(0, 1));
      p.second = random_insn();
      pending.push_back(p);
    end
    total_items = pending.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_taken < total_items || retire_q.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Ran %0d instruction pairs, %0d retirements checked, %0d mismatching fields.",
             items_taken, results_seen, mismatches);
    $display("Covered %0d dual issues, %0d load-use stalls, %0d control bubbles; halted = %0b.",
             dual_issues, load_stalls, branch_bubbles, halted_m);
    if (mismatches == 0 && retire_q.size() == 0) begin
      $display("** dual_issue_pipeline_hazard_control: PASSED **");
    end else begin
      $display("** dual_issue_pipeline_hazard_control: FAILED **");
    end
    $finish;
  end

endmodule
